// File: hw/rtl/cbpb_pkg.sv
package cbpb_pkg;

    localparam int PORTS_DEF     = 8;
    localparam int DATA_BITS_DEF = 32;

    localparam int LAT_W     = 8;
    localparam int STAMP_W   = 8;
    localparam int DEST_W    = 3;
    localparam int PAY_W     = 32;
    localparam int RMASK_W   = 8;
    localparam int OPORT_W   = 3;

    // input tdata: dest_port, payload, ready_mask
    localparam int S_DEST_LSB  = 0;
    localparam int S_PAY_LSB   = S_DEST_LSB + DEST_W;
    localparam int S_RMASK_LSB = S_PAY_LSB + PAY_W;
    localparam int S_USED_W    = S_RMASK_LSB + RMASK_W;
    localparam int S_TDATA_W   = ((S_USED_W + 7) / 8) * 8;

    // output tdata: accepted, deliver_valid, out_port, out_payload
    localparam int M_ACC_LSB   = 0;
    localparam int M_DV_LSB    = 1;
    localparam int M_PORT_LSB  = 2;
    localparam int M_PAY_LSB   = M_PORT_LSB + OPORT_W;
    localparam int M_USED_W    = M_PAY_LSB + PAY_W;
    localparam int M_TDATA_W   = ((M_USED_W + 7) / 8) * 8;

    localparam logic OP_RECV = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [LAT_W-1:0] LAT_RESET = 8'd1;

    // steps of the bit-serial remainder of (phase + 1) by latency
    localparam int MOD_STEPS = LAT_W + 1;
    localparam int STEP_W    = 4;

    typedef struct packed {
        logic move;
        logic deliver;
        logic out_busy;
    } t_port_ctl;

endpackage

// File: hw/rtl/cbpb_slot_ram.sv
module cbpb_slot_ram #(
    parameter int DEPTH = cbpb_pkg::PORTS_DEF,
    parameter int WIDTH = cbpb_pkg::DATA_BITS_DEF + cbpb_pkg::STAMP_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/cbpb_port_unit.sv
module cbpb_port_unit #(
    parameter int DATA_BITS = cbpb_pkg::DATA_BITS_DEF
) (
    input  logic                         i_phase_zero,
    input  logic                         i_in_busy,
    input  logic                         i_out_busy,
    input  logic                         i_ready,
    input  logic [cbpb_pkg::STAMP_W-1:0] i_in_stamp,
    input  logic [cbpb_pkg::STAMP_W-1:0] i_out_stamp,
    input  logic [DATA_BITS-1:0]         i_in_data,
    input  logic [DATA_BITS-1:0]         i_out_data,
    output cbpb_pkg::t_port_ctl          o_ctl,
    output logic [DATA_BITS-1:0]         o_data
);
    import cbpb_pkg::*;

    logic w_older;
    logic w_busy_after;

    // output slot holds an older packet: input slot waits
    assign w_older      = i_out_busy && (i_out_stamp < i_in_stamp);
    assign o_ctl.move   = i_phase_zero && i_in_busy && !w_older;
    assign w_busy_after = o_ctl.move || i_out_busy;
    assign o_ctl.deliver  = i_phase_zero && w_busy_after && i_ready;
    assign o_ctl.out_busy = w_busy_after && !o_ctl.deliver;
    assign o_data = o_ctl.move ? i_in_data : i_out_data;

endmodule

// File: hw/rtl/ideal_crossbar_port_buffers.sv
// Crossbar port buffers: one input slot and one output slot per port.
// Slave stream: tuser = opcode (receive or tick); tdata carries dest_port,
// payload and ready_mask. Master stream: one result per transfer; tdata
// carries accepted, deliver_valid, out_port, out_payload; tlast marks the
// final result of an input item.
// Receive: the result is in the output register in the cycle after the
// input transfer. Tick: a 9-step bit-serial remainder unit advances the
// phase counter modulo latency_period, then the sequencer visits one port per
// cycle unless the receiver stalls, reading its slots from the slot RAMs and
// driving the shared stamp-compare/move/deliver unit: one result per port,
// and tready stays low until the last port is done.
// The block takes one item at a time; tready is high only when idle and the
// output register is empty or draining.
// A receiver stall holds the output register and halts the port sequencer.
// Reset (synchronous, active low) clears all busy bits, the phase counter and
// the output valid, and sets latency_period to 1. i_cfg_we writes
// latency_period at once; write it only while idle.
module ideal_crossbar_port_buffers #(
    parameter int PORTS     = cbpb_pkg::PORTS_DEF,
    parameter int DATA_BITS = cbpb_pkg::DATA_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // dest_port[2:0], payload[34:3], ready_mask[42:35]
    input  logic [cbpb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // accepted[0], deliver_valid[1], out_port[4:2], out_payload[36:5]
    output logic [cbpb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           i_cfg_we,
    input  logic [cbpb_pkg::LAT_W-1:0]     i_cfg_wdata
);
    import cbpb_pkg::*;

    localparam int AW = $clog2(PORTS);
    localparam int SW = STAMP_W + DATA_BITS;
    localparam logic [AW-1:0] LAST_PORT = AW'(PORTS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_EX   = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [LAT_W-1:0]   r_lat;
    logic [STAMP_W-1:0] r_phase;
    logic               r_phz;
    logic [LAT_W-1:0]   r_rem;
    logic [LAT_W:0]     r_div;
    logic [STEP_W-1:0]  r_step;
    logic [AW-1:0]      r_port;
    logic [PORTS-1:0]   r_ready;
    logic [PORTS-1:0]   r_in_busy;
    logic [PORTS-1:0]   r_out_busy;

    logic               r_m_valid;
    logic               r_m_acc;
    logic               r_m_dv;
    logic [OPORT_W-1:0] r_m_port;
    logic [PAY_W-1:0]   r_m_pay;
    logic               r_m_last;

    logic [DEST_W-1:0]  w_dest;
    logic [PAY_W-1:0]   w_pay;
    logic [RMASK_W-1:0] w_rmask;
    logic [PORTS-1:0]   w_ready_vec;
    logic [AW-1:0]      w_dest_idx;
    logic               w_out_free;
    logic               w_s_fire;
    logic               w_rx;
    logic               w_tick;
    logic               w_rx_ok;
    logic               w_ex_fire;
    logic [AW-1:0]      w_raddr;
    logic [SW-1:0]      w_in_rd;
    logic [SW-1:0]      w_out_rd;
    logic [LAT_W:0]     w_trial;
    logic [LAT_W-1:0]   n_rem;
    logic               w_mod_done;
    t_port_ctl          w_ctl;
    logic [DATA_BITS-1:0] w_data;

    assign w_dest  = s_axis_tdata[S_DEST_LSB +: DEST_W];
    assign w_pay   = s_axis_tdata[S_PAY_LSB +: PAY_W];
    assign w_rmask = s_axis_tdata[S_RMASK_LSB +: RMASK_W];

    for (genvar gi = 0; gi < PORTS; gi++) begin : g_rdy
        if (gi < RMASK_W) begin : g_in
            assign w_ready_vec[gi] = w_rmask[gi];
        end else begin : g_none
            assign w_ready_vec[gi] = 1'b0;
        end
    end

    assign w_dest_idx = AW'(w_dest);
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_s_fire = s_axis_tvalid && s_axis_tready;
    assign w_rx     = w_s_fire && (s_axis_tuser == OP_RECV);
    assign w_tick   = w_s_fire && (s_axis_tuser == OP_TICK);
    assign w_rx_ok  = (32'(w_dest) < PORTS) && !r_in_busy[w_dest_idx];
    assign w_ex_fire = (r_state == ST_EX) && w_out_free;

    assign w_raddr = (w_ex_fire && (r_port != LAST_PORT)) ? r_port + AW'(1) : r_port;

    // remainder step
    assign w_trial    = {r_rem, r_div[LAT_W]};
    assign n_rem      = (w_trial >= {1'b0, r_lat}) ? LAT_W'(w_trial - {1'b0, r_lat})
                                                   : LAT_W'(w_trial);
    assign w_mod_done = (r_step == STEP_W'(MOD_STEPS - 1));

    cbpb_slot_ram #(.DEPTH(PORTS), .WIDTH(SW)) u_in_ram (
        .i_clk   (i_clk),
        .i_we    (w_rx && w_rx_ok),
        .i_waddr (w_dest_idx),
        .i_wdata ({r_phase, DATA_BITS'(w_pay)}),
        .i_raddr (w_raddr),
        .o_rdata (w_in_rd)
    );

    cbpb_slot_ram #(.DEPTH(PORTS), .WIDTH(SW)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (w_ex_fire && w_ctl.move),
        .i_waddr (r_port),
        .i_wdata (w_in_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_out_rd)
    );

    cbpb_port_unit #(.DATA_BITS(DATA_BITS)) u_port (
        .i_phase_zero (r_phz),
        .i_in_busy    (r_in_busy[r_port]),
        .i_out_busy   (r_out_busy[r_port]),
        .i_ready      (r_ready[r_port]),
        .i_in_stamp   (w_in_rd[DATA_BITS +: STAMP_W]),
        .i_out_stamp  (w_out_rd[DATA_BITS +: STAMP_W]),
        .i_in_data    (w_in_rd[DATA_BITS-1:0]),
        .i_out_data   (w_out_rd[DATA_BITS-1:0]),
        .o_ctl        (w_ctl),
        .o_data       (w_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_tick) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (w_mod_done) begin
                    n_state = ST_EX;
                end
            end
            ST_EX: begin
                if (w_ex_fire && (r_port == LAST_PORT)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_lat      <= LAT_RESET;
            r_phase    <= '0;
            r_phz      <= 1'b0;
            r_step     <= '0;
            r_port     <= '0;
            r_in_busy  <= '0;
            r_out_busy <= '0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_lat <= i_cfg_wdata;
            end
            if (w_rx && w_rx_ok) begin
                r_in_busy[w_dest_idx] <= 1'b1;
            end
            if (w_tick) begin
                r_step <= '0;
                r_port <= '0;
            end
            if (r_state == ST_MOD) begin
                r_step <= r_step + STEP_W'(1);
                if (w_mod_done) begin
                    r_phase <= (r_lat == '0) ? '0 : n_rem;
                    r_phz   <= (r_lat == '0) || (n_rem == '0);
                end
            end
            if (w_ex_fire) begin
                if (w_ctl.move) begin
                    r_in_busy[r_port] <= 1'b0;
                end
                r_out_busy[r_port] <= w_ctl.out_busy;
                if (r_port != LAST_PORT) begin
                    r_port <= r_port + AW'(1);
                end
            end
            if (w_rx || w_ex_fire) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tick) begin
            r_ready <= w_ready_vec;
            r_rem   <= '0;
            r_div   <= {1'b0, r_phase} + (LAT_W + 1)'(1);
        end else if (r_state == ST_MOD) begin
            r_rem <= n_rem;
            r_div <= {r_div[LAT_W-1:0], 1'b0};
        end
        if (w_rx) begin
            r_m_acc  <= w_rx_ok;
            r_m_dv   <= 1'b0;
            r_m_port <= w_dest;
            r_m_pay  <= '0;
            r_m_last <= 1'b1;
        end else if (w_ex_fire) begin
            r_m_acc  <= 1'b0;
            r_m_dv   <= w_ctl.deliver;
            r_m_port <= OPORT_W'(r_port);
            r_m_pay  <= w_ctl.deliver ? PAY_W'(w_data) : '0;
            r_m_last <= (r_port == LAST_PORT);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = M_TDATA_W'({r_m_pay, r_m_port, r_m_dv, r_m_acc});

endmodule

// File: hw/rtl/cbpb_checker.sv
module cbpb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tvalid,
    input logic                           s_axis_tready,
    input logic                           s_axis_tuser,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [cbpb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                           m_axis_tlast
);
    import cbpb_pkg::*;

    // a receive transfer yields its single result on the next cycle
    a_rx_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_RECV))
        |=> (m_axis_tvalid && m_axis_tlast && !m_axis_tdata[M_DV_LSB]))
        else $error("receive result missing");

    // no new input while a result is stalled
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken during output stall");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[M_ACC_LSB] && m_axis_tdata[M_DV_LSB]))
        else $error("accepted and deliver_valid both set");

    a_pay_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[M_DV_LSB])
        |-> (m_axis_tdata[M_PAY_LSB +: PAY_W] == '0))
        else $error("payload without delivery");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(m_axis_tvalid && !m_axis_tready) && $past(i_rst_n))
        |-> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind ideal_crossbar_port_buffers cbpb_checker u_cbpb_checker (.*);

// File: tb/ideal_crossbar_port_buffers_tb.sv
`timescale 1ns / 1ps

module ideal_crossbar_port_buffers_tb;
    import cbpb_pkg::*;

    localparam int PORTS = PORTS_DEF;

    typedef struct {
        logic               op;
        logic [DEST_W-1:0]  dest;
        logic [PAY_W-1:0]   payload;
        logic [RMASK_W-1:0] mask;
    } t_pkt_item;

    typedef struct {
        logic               acc;
        logic               dv;
        logic [OPORT_W-1:0] port;
        logic [PAY_W-1:0]   payload;
        logic               last;
    } t_port_report;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = OP_RECV;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [LAT_W-1:0]     i_cfg_wdata = '0;

    ideal_crossbar_port_buffers #(
        .PORTS     (PORTS),
        .DATA_BITS (DATA_BITS_DEF)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // predicted slot state
    logic [LAT_W-1:0]   lat_now = LAT_RESET;
    logic [STAMP_W-1:0] phase_now = '0;
    bit                 in_busy   [PORTS];
    bit [PAY_W-1:0]     in_data   [PORTS];
    bit [STAMP_W-1:0]   in_stamp  [PORTS];
    bit                 out_busy  [PORTS];
    bit [PAY_W-1:0]     out_data  [PORTS];
    bit [STAMP_W-1:0]   out_stamp [PORTS];

    t_pkt_item    pkt_q[$];
    t_port_report port_reports_q[$];
    t_pkt_item    drv_item;
    bit           feeding = 1'b0;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int unsigned rcv_hold = 0;

    int err_cnt = 0;
    int n_items = 0;
    int n_results = 0;
    int n_delivered = 0;
    int n_refused = 0;
    int n_cfg = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic crossbar_step(input t_pkt_item it);
        t_port_report r;
        int p;
        if (it.op == OP_RECV) begin
            r = '{default: '0};
            r.port = it.dest;
            r.last = 1'b1;
            if (!in_busy[it.dest]) begin
                in_busy[it.dest]  = 1'b1;
                in_data[it.dest]  = it.payload;
                in_stamp[it.dest] = phase_now;
                r.acc = 1'b1;
            end else begin
                n_refused++;
            end
            port_reports_q.push_back(r);
        end else begin
            if (lat_now == '0)
                phase_now = '0;
            else
                phase_now = STAMP_W'((9'(phase_now) + 9'd1) % 9'(lat_now));
            if (phase_now == '0) begin
                for (p = 0; p < PORTS; p++) begin
                    // an older stamp waiting in the output slot blocks the move
                    if (in_busy[p] && !(out_busy[p] && out_stamp[p] < in_stamp[p])) begin
                        out_data[p]  = in_data[p];
                        out_stamp[p] = in_stamp[p];
                        out_busy[p]  = 1'b1;
                        in_busy[p]   = 1'b0;
                    end
                end
            end
            for (p = 0; p < PORTS; p++) begin
                r = '{default: '0};
                r.port = OPORT_W'(p);
                r.last = (p == PORTS - 1);
                if (phase_now == '0 && out_busy[p] && it.mask[p]) begin
                    r.dv = 1'b1;
                    r.payload = out_data[p];
                    out_busy[p] = 1'b0;
                    n_delivered++;
                end
                port_reports_q.push_back(r);
            end
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n && !feeding) begin
            if (pkt_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                drv_item = pkt_q.pop_front();
                feeding = 1'b1;
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= drv_item.op;
                s_axis_tdata  <= S_TDATA_W'({drv_item.mask, drv_item.payload, drv_item.dest});
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (rcv_hold != 0) begin
            m_axis_tready <= 1'b0;
            rcv_hold--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // input transfer
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            crossbar_step(drv_item);
            feeding = 1'b0;
            n_items++;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_port_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            if (port_reports_q.size() == 0) begin
                $error("result with nothing expected: tdata %h tlast %b",
                       m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end else begin
                want = port_reports_q.pop_front();
                if (m_axis_tdata[M_ACC_LSB] !== want.acc) begin
                    $error("accepted: expected %b, got %b", want.acc, m_axis_tdata[M_ACC_LSB]);
                    err_cnt++;
                end
                if (m_axis_tdata[M_DV_LSB] !== want.dv) begin
                    $error("deliver_valid: expected %b, got %b", want.dv,
                           m_axis_tdata[M_DV_LSB]);
                    err_cnt++;
                end
                if (m_axis_tdata[M_PORT_LSB +: OPORT_W] !== want.port) begin
                    $error("out_port: expected %0d, got %0d", want.port,
                           m_axis_tdata[M_PORT_LSB +: OPORT_W]);
                    err_cnt++;
                end
                if (m_axis_tdata[M_PAY_LSB +: PAY_W] !== want.payload) begin
                    $error("out_payload: expected %h, got %h", want.payload,
                           m_axis_tdata[M_PAY_LSB +: PAY_W]);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push_item(input logic op, input int dest, input logic [PAY_W-1:0] pay,
                             input logic [RMASK_W-1:0] mask);
        t_pkt_item it;
        it.op      = op;
        it.dest    = DEST_W'(dest);
        it.payload = pay;
        it.mask    = mask;
        pkt_q.push_back(it);
    endtask

    task automatic add_recv(input int dest, input logic [PAY_W-1:0] pay);
        push_item(OP_RECV, dest, pay, RMASK_W'($urandom_range(255)));
    endtask

    task automatic add_tick(input logic [RMASK_W-1:0] mask);
        push_item(OP_TICK, $urandom_range(7), $urandom(), mask);
    endtask

    task automatic add_random(input int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(99) < 55)
                add_recv($urandom_range(7), $urandom());
            else
                add_tick(RMASK_W'($urandom_range(255)));
        end
    endtask

    task automatic drain();
        while (pkt_q.size() != 0 || feeding || port_reports_q.size() != 0)
            @(negedge i_clk);
        repeat (PORTS + 10) @(negedge i_clk);
    endtask

    task automatic set_latency(input int v);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= LAT_W'(v);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        lat_now = LAT_W'(v);
        n_cfg++;
    endtask

    task automatic run_phase(input int lat, input int snd_pct, input int rcv_pct,
                             input int n);
        set_latency(lat);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        add_random(n);
        drain();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // latency 1 from reset: every tick is a transfer phase
        add_recv(0, 32'h0000_0000);
        add_recv(7, 32'hFFFF_FFFF);
        add_recv(0, 32'h1234_5678);
        add_tick(8'h00);
        add_recv(0, 32'hA5A5_A5A5);
        add_tick(8'h00);
        add_tick(8'hFF);
        add_tick(8'hFF);
        drain();

        // older stamp in the output slot holds the newer packet back
        set_latency(3);
        add_recv(1, 32'h1111_1111);
        add_tick(8'h00);
        add_tick(8'h00);
        add_tick(8'h00);
        add_tick(8'h00);
        add_recv(1, 32'h2222_2222);
        add_tick(8'h00);
        add_tick(8'h00);
        add_tick(8'h80);
        add_tick(8'h02);
        add_tick(8'h02);
        drain();

        // counter left above a smaller latency
        set_latency(255);
        repeat (4) add_tick(8'hFF);
        set_latency(2);
        add_tick(8'hFF);
        add_tick(8'hFF);
        drain();

        run_phase(0, 0, 0, 100);
        run_phase(1, 51, 0, 100);
        run_phase(2, 0, 51, 100);
        run_phase($urandom_range(3, 6), 27, 27, 80);

        // long receiver hold-off while items keep coming
        set_latency(1);
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        rcv_hold = 400;
        add_random(40);
        drain();

        run_phase(255, 27, 27, 20);

        drain();
        $display("Run covered %0d items and %0d transfers out (%0d deliveries, %0d refused)",
                 n_items, n_results, n_delivered, n_refused);
        $display("over %0d latency writes including 0 and 255, with idle and stall phases",
                 n_cfg);
        if (err_cnt == 0)
            $display("** ideal_crossbar_port_buffers: PASSED **");
        else
            $display("** ideal_crossbar_port_buffers: FAILED **");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("** ideal_crossbar_port_buffers: FAILED **");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/cbpb_pkg.sv
hw/rtl/cbpb_slot_ram.sv
hw/rtl/cbpb_port_unit.sv
hw/rtl/ideal_crossbar_port_buffers.sv
hw/rtl/cbpb_checker.sv
tb/ideal_crossbar_port_buffers_tb.sv
